// ===== src/nth_fibonacci_fast_doubling_defines.svh =====
// Assertion macros used by the Fibonacci fast-doubling controller.
`ifndef NTH_FIBONACCI_FAST_DOUBLING_DEFINES_SVH
`define NTH_FIBONACCI_FAST_DOUBLING_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define FIBFD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fast doubling assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define FIBFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fast doubling assertion failed");

`endif

// ===== src/fibfd_pkg.sv =====
// Types and constants shared by the Fibonacci fast-doubling controller and datapath.
package fibfd_pkg;

    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int INDEX_W    = 32;
    localparam int WRAP_LIMIT = 93;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DRAIN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    // Which product a partial product belongs to.
    typedef enum logic [1:0] {
        PROD_C,
        PROD_AA,
        PROD_BB
    } prod_t;

    // Which 32-bit halves feed the multiplier.
    typedef enum logic [1:0] {
        PART_LL,
        PART_LH,
        PART_HL
    } part_t;

    typedef struct packed {
        logic  load;
        logic  prep;
        logic  issue;
        prod_t prod;
        part_t part;
        logic  update;
        logic  take_odd;
        logic  load_out;
    } cmd_t;

    typedef struct packed {
        logic bit_set;
    } status_t;

endpackage

// ===== src/nth_fibonacci_fast_doubling.sv =====
// Per index bit the controller runs PREP, MUL, DRAIN and UPDATE; FINISH then loads the result.
// Requests are taken only in IDLE, after the last result is loaded; a result may wait in the output register.
// Each index bit takes nine issues of the single shared 32x32 multiplier besides PREP, DRAIN and UPDATE.
// The multiplier builds F(k)*(2F(k+1)-F(k)), F(k)^2 and F(k+1)^2 modulo 2^64 from partial products.
// Reset (rst_n, asynchronous, active low) clears the controller and output valid; no memory clear.
module nth_fibonacci_fast_doubling #(
    parameter int INDEX_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fibfd_pkg::INDEX_W-1:0] index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fibfd_pkg::WORD_W-1:0]  value,
    output logic                          wrapped
);
    import fibfd_pkg::*;

    cmd_t    cmd;
    status_t status;

    fibfd_ctrl #(
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    fibfd_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .index   (index),
        .value   (value),
        .wrapped (wrapped)
    );

endmodule

// ===== src/fibfd_dp.sv =====
// Datapath: Fibonacci pair, shared 32x32 multiplier, accumulators and result registers.
module fibfd_dp #(
    parameter int INDEX_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fibfd_pkg::cmd_t                    cmd,
    output fibfd_pkg::status_t                 status,
    input  logic [fibfd_pkg::INDEX_W-1:0]      index,
    output logic [fibfd_pkg::WORD_W-1:0]       value,
    output logic                               wrapped
);
    import fibfd_pkg::*;

    localparam int EXT_W = INDEX_BITS + INDEX_W;

    logic [WORD_W-1:0]     a_reg;
    logic [WORD_W-1:0]     b_reg;
    logic [WORD_W-1:0]     t_reg;
    logic [WORD_W-1:0]     c_reg;
    logic [WORD_W-1:0]     d_reg;
    logic [WORD_W-1:0]     mul_reg;
    logic [WORD_W-1:0]     value_reg;
    logic                  wrapped_reg;
    logic                  wrap_reg;
    logic [INDEX_BITS-1:0] held_reg;

    logic                  acc_en_reg;
    prod_t                 acc_prod_reg;
    part_t                 acc_part_reg;

    logic [EXT_W-1:0]      index_ext;
    logic [INDEX_BITS-1:0] masked;
    logic [EXT_W-1:0]      n_wide;
    logic [WORD_W-1:0]     mul_x;
    logic [WORD_W-1:0]     mul_y;
    logic [HALF_W-1:0]     op_x;
    logic [HALF_W-1:0]     op_y;
    logic [WORD_W-1:0]     mul_next;
    logic [WORD_W-1:0]     addend;
    logic [WORD_W-1:0]     sum_cd;

    // Index bits at or above INDEX_BITS are dropped; narrower ports are zero-extended.
    assign index_ext = {{INDEX_BITS{1'b0}}, index};
    assign masked    = index_ext[INDEX_BITS-1:0];
    assign n_wide    = EXT_W'(masked);

    always_comb
    begin
        case (cmd.prod)
            PROD_C:
            begin
                mul_x = a_reg;
                mul_y = t_reg;
            end
            PROD_AA:
            begin
                mul_x = a_reg;
                mul_y = a_reg;
            end
            default:
            begin
                mul_x = b_reg;
                mul_y = b_reg;
            end
        endcase
        case (cmd.part)
            PART_LL:
            begin
                op_x = mul_x[HALF_W-1:0];
                op_y = mul_y[HALF_W-1:0];
            end
            PART_LH:
            begin
                op_x = mul_x[HALF_W-1:0];
                op_y = mul_y[WORD_W-1:HALF_W];
            end
            default:
            begin
                op_x = mul_x[WORD_W-1:HALF_W];
                op_y = mul_y[HALF_W-1:0];
            end
        endcase
    end

    assign mul_next = WORD_W'(op_x) * WORD_W'(op_y);

    // Cross products only reach the upper half of a product taken modulo 2^64.
    assign addend = (acc_part_reg == PART_LL) ? mul_reg
                                              : {mul_reg[HALF_W-1:0], {HALF_W{1'b0}}};
    assign sum_cd = c_reg + d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg   <= 1'b0;
            acc_prod_reg <= PROD_C;
            acc_part_reg <= PART_LL;
        end
        else
        begin
            acc_en_reg   <= cmd.issue;
            acc_prod_reg <= cmd.prod;
            acc_part_reg <= cmd.part;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= '0;
            b_reg    <= WORD_W'(1);
            held_reg <= masked;
            wrap_reg <= (n_wide > EXT_W'(WRAP_LIMIT));
        end
        else if (cmd.update)
        begin
            held_reg <= held_reg << 1;
            if (cmd.take_odd)
            begin
                a_reg <= d_reg;
                b_reg <= sum_cd;
            end
            else
            begin
                a_reg <= c_reg;
                b_reg <= d_reg;
            end
        end

        if (cmd.prep)
        begin
            t_reg <= (b_reg << 1) - a_reg;
            c_reg <= '0;
            d_reg <= '0;
        end
        else if (acc_en_reg)
        begin
            if (acc_prod_reg == PROD_C)
            begin
                c_reg <= c_reg + addend;
            end
            else
            begin
                d_reg <= d_reg + addend;
            end
        end

        if (cmd.issue)
        begin
            mul_reg <= mul_next;
        end

        if (cmd.load_out)
        begin
            value_reg   <= a_reg;
            wrapped_reg <= wrap_reg;
        end
    end

    assign status.bit_set = held_reg[INDEX_BITS-1];
    assign value          = value_reg;
    assign wrapped        = wrapped_reg;

endmodule

// ===== src/fibfd_ctrl.sv =====
// Controller: sequences the doubling steps, the multiplier partial products and the handshakes.
`include "nth_fibonacci_fast_doubling_defines.svh"

module fibfd_ctrl #(
    parameter int INDEX_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  fibfd_pkg::status_t status,
    output fibfd_pkg::cmd_t    cmd
);
    import fibfd_pkg::*;

    localparam int POS_W = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(INDEX_BITS - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [POS_W-1:0] bit_cnt_reg;
    logic [POS_W-1:0] bit_cnt_next;
    prod_t            prod_reg;
    prod_t            prod_next;
    part_t            part_reg;
    part_t            part_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            prod_reg      <= PROD_C;
            part_reg      <= PART_LL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            prod_reg      <= prod_next;
            part_reg      <= part_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        prod_next    = prod_reg;
        part_next    = part_reg;
        cmd          = '0;
        in_ready     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = LAST_POS;
                    state_next   = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                prod_next  = PROD_C;
                part_next  = PART_LL;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // Three products of three partial products each, one per cycle.
                cmd.issue = 1'b1;
                cmd.prod  = prod_reg;
                cmd.part  = part_reg;
                case (part_reg)
                    PART_LL: part_next = PART_LH;
                    PART_LH: part_next = PART_HL;
                    default:
                    begin
                        part_next = PART_LL;
                        case (prod_reg)
                            PROD_C:  prod_next = PROD_AA;
                            PROD_AA: prod_next = PROD_BB;
                            default: state_next = ST_DRAIN;
                        endcase
                    end
                endcase
            end
            ST_DRAIN:
            begin
                // The last partial product is added into its accumulator here.
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update   = 1'b1;
                cmd.take_odd = status.bit_set;
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - POS_W'(1);
                    state_next   = ST_PREP;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `FIBFD_ASSERT_NEXT(a_load_starts_walk, in_valid && in_ready,
        state_reg == ST_PREP && bit_cnt_reg == LAST_POS)
    `FIBFD_ASSERT_NEXT(a_mul_ends_in_drain,
        state_reg == ST_MUL && prod_reg == PROD_BB && part_reg == PART_HL,
        state_reg == ST_DRAIN)
    `FIBFD_ASSERT_NEXT(a_last_bit_finishes, state_reg == ST_UPDATE && bit_cnt_reg == '0,
        state_reg == ST_FINISH)
    `FIBFD_ASSERT_IMPL(a_no_result_overwrite, cmd.load_out, !out_valid_reg || out_ready)
    `FIBFD_ASSERT_NEXT(a_result_follows_load, cmd.load_out, out_valid_reg)

endmodule
